FILE: rtl/psw_pkg.sv
`timescale 1ns / 1ps

package psw_pkg;

    localparam int unsigned DivBits = 20;
    localparam int unsigned CntBits = $clog2(DivBits);
    localparam logic [DivBits-1:0] TICKS_PER_SEC = 20'd921600;
    localparam logic [14:0] LOW_LIMIT  = 15'd500;
    localparam logic [14:0] HIGH_LIMIT = 15'd4000;
    localparam logic [DivBits-1:0] LOW_CORR  = 20'd100;
    localparam logic [DivBits-1:0] MID_CORR  = 20'd30;
    localparam logic [DivBits-1:0] HIGH_CORR = 20'd10;

    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_SET  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic exec;
        logic div_start;
        logic div_step;
        logic div_finish;
    } t_cmd;

    typedef struct packed {
        logic set_nz;
        logic div_last;
    } t_sts;

endpackage

FILE: rtl/psw_if.sv
`timescale 1ns / 1ps

interface psw_in_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [13:0] freq_hz;

    modport source (output valid, output req_type, output freq_hz, input ready);
    modport sink (input valid, input req_type, input freq_hz, output ready);
endinterface

interface psw_out_if;
    logic        valid;
    logic        ready;
    logic        wave_level;
    logic        running;
    logic [18:0] half_period_ticks;

    modport source (output valid, output wave_level, output running,
                    output half_period_ticks, input ready);
    modport sink (input valid, input wave_level, input running,
                  input half_period_ticks, output ready);
endinterface

FILE: rtl/psw_ctrl.sv
`timescale 1ns / 1ps

module psw_ctrl import psw_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_accept;
    logic   w_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        w_accept   = 1'b0;
        w_load     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = !r_out_valid || i_out_ready;
                w_accept   = o_in_ready && i_in_valid;
                if (w_accept) begin
                    if (i_sts.set_nz) begin
                        o_cmd.div_start = 1'b1;
                        n_state         = ST_DIV;
                    end else begin
                        o_cmd.exec = 1'b1;
                        w_load     = 1'b1;
                    end
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                o_cmd.div_finish = 1'b1;
                w_load           = 1'b1;
                n_state          = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        n_out_valid = (r_out_valid && !i_out_ready) || w_load;
    end

    assign o_out_valid = r_out_valid;

endmodule

FILE: rtl/psw_dp.sv
`timescale 1ns / 1ps

module psw_dp import psw_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_type,
    input  logic [13:0] i_freq_hz,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    output logic        o_wave_level,
    output logic        o_running,
    output logic [18:0] o_half_period_ticks
);

    logic               r_level, n_level;
    logic               r_active, n_active;
    logic [18:0]        r_half, n_half;
    logic [18:0]        r_count, n_count;
    logic [14:0]        r_div;
    logic [14:0]        r_rem, n_rem;
    logic [DivBits-1:0] r_quo, n_quo;
    logic [CntBits-1:0] r_step;
    logic [15:0]        w_trial;
    logic [15:0]        w_diff;
    logic [18:0]        w_count_inc;
    logic [DivBits-1:0] w_base;

    assign o_sts.set_nz   = (i_req_type == REQ_SET) && (i_freq_hz != 14'd0);
    assign o_sts.div_last = (r_step == CntBits'(DivBits - 1));

    // one restoring step per cycle
    assign w_trial = {r_rem, r_quo[DivBits-1]};
    assign w_diff  = w_trial - {1'b0, r_div};

    always_comb begin
        if (w_trial >= {1'b0, r_div}) begin
            n_rem = w_diff[14:0];
            n_quo = {r_quo[DivBits-2:0], 1'b1};
        end else begin
            n_rem = w_trial[14:0];
            n_quo = {r_quo[DivBits-2:0], 1'b0};
        end
    end

    always_comb begin
        if (r_div < LOW_LIMIT) begin
            w_base = r_quo + LOW_CORR;
        end else if (r_div > HIGH_LIMIT) begin
            w_base = r_quo - HIGH_CORR;
        end else begin
            w_base = r_quo + MID_CORR;
        end
    end

    assign w_count_inc = r_count + 19'd1;

    always_comb begin
        n_level  = r_level;
        n_active = r_active;
        n_half   = r_half;
        n_count  = r_count;
        if (i_cmd.exec) begin
            if (i_req_type == REQ_SET) begin
                n_active = 1'b0;
                n_half   = '0;
                n_count  = '0;
            end else if (r_active) begin
                if (w_count_inc >= r_half) begin
                    n_level = !r_level;
                    n_count = '0;
                end else begin
                    n_count = w_count_inc;
                end
            end
        end else if (i_cmd.div_finish) begin
            n_active = 1'b1;
            n_half   = w_base[18:0];
            n_count  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level  <= 1'b0;
            r_active <= 1'b0;
            r_half   <= '0;
            r_count  <= '0;
            r_step   <= '0;
        end else begin
            r_level  <= n_level;
            r_active <= n_active;
            r_half   <= n_half;
            r_count  <= n_count;
            if (i_cmd.div_start) begin
                r_step <= '0;
            end else if (i_cmd.div_step) begin
                r_step <= r_step + CntBits'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_div <= {i_freq_hz, 1'b0};
            r_rem <= '0;
            r_quo <= TICKS_PER_SEC;
        end else if (i_cmd.div_step) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
        if (i_cmd.exec || i_cmd.div_finish) begin
            o_wave_level        <= n_level;
            o_running           <= n_active;
            o_half_period_ticks <= n_half;
        end
    end

endmodule

FILE: rtl/programmable_square_wave_generator_top.sv
`timescale 1ns / 1ps

// channel | dir | modport | payload
// i_in    | in  | sink    | req_type, freq_hz
// o_out   | out | source  | wave_level, running, half_period_ticks
//
// a tick item or a zero set item is handled in idle; one item a cycle while o_out drains
// a nonzero set item is taken in idle, then run through the bit-per-cycle divider,
// then corrected and loaded as the result
// the result is held in an output register, so the next item is taken while it is read
// i_rst_n is synchronous: internal wave low, stopped, half period and tick count zero
// i_in is held off during a division and while a result waits and o_out.ready is low

module programmable_square_wave_generator_top import psw_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    psw_in_if.sink    i_in,
    psw_out_if.source o_out
);

    t_cmd w_cmd;
    t_sts w_sts;

    psw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    psw_dp u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_req_type          (i_in.req_type),
        .i_freq_hz           (i_in.freq_hz),
        .i_cmd               (w_cmd),
        .o_sts               (w_sts),
        .o_wave_level        (o_out.wave_level),
        .o_running           (o_out.running),
        .o_half_period_ticks (o_out.half_period_ticks)
    );

endmodule
